// ===== sv/lcs_pkg.sv =====
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared constants, status codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package lcs_pkg;

   localparam int DefaultWidth = 63;

   // result status codes
   localparam logic [1:0] STATUS_SOLVED  = 2'd0;
   localparam logic [1:0] STATUS_NOSOL   = 2'd1;
   localparam logic [1:0] STATUS_ZEROMOD = 2'd2;

   // datapath operations
   localparam logic [3:0] OP_NONE    = 4'd0;
   localparam logic [3:0] OP_LOAD    = 4'd1;  // latch inputs
   localparam logic [3:0] OP_DIV_A   = 4'd2;  // start a mod n
   localparam logic [3:0] OP_DIV_B   = 4'd3;  // start b mod n
   localparam logic [3:0] OP_DIV_Q   = 4'd4;  // start r0 / r1
   localparam logic [3:0] OP_QMUL    = 4'd5;  // start q*s1 (serial)
   localparam logic [3:0] OP_EUCLID  = 4'd6;  // apply quotient step
   localparam logic [3:0] OP_DIV_BD  = 4'd7;  // start b / d
   localparam logic [3:0] OP_DIV_U   = 4'd8;  // start |u| mod n
   localparam logic [3:0] OP_DIV_NS  = 4'd9;  // start n / d
   localparam logic [3:0] OP_MULMOD  = 4'd10; // start u*k mod n
   localparam logic [3:0] OP_FIX_U   = 4'd11; // make u nonnegative

   typedef struct packed {
      logic [3:0] op;
   } cmd_type;

   typedef struct packed {
      logic unit_done;   // divider or serial unit finished this cycle
      logic r1_zero;
      logic n_zero;
      logic rem_zero;    // last divider remainder is zero
   } stat_type;

endpackage

// ===== sv/linear_congruence_solver.sv =====
// A new item is taken only after the last result; the divider and multipliers are shared bit-serial units.
// busy is high from acceptance until the result strobe; start is taken only when idle.
// Results appear on rsp_ for one cycle with rsp_valid; the receiver cannot stall.
// Synchronous active-high reset returns the sequencer to idle.
// ----------------------------------------------------------------------------
// linear_congruence_solver
// Solves a*x = b mod n with extended Euclid; returns gcd, first solution, step.
// ----------------------------------------------------------------------------
module linear_congruence_solver
   import lcs_pkg::*;
#(
   parameter int WIDTH = DefaultWidth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [WIDTH-1:0] req_coeff,
   input  logic [WIDTH-1:0] req_rhs,
   input  logic [WIDTH-1:0] req_modulus,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [WIDTH-1:0] rsp_divisor,
   output logic [WIDTH-1:0] rsp_first_solution,
   output logic [WIDTH-1:0] rsp_solution_step
);
   cmd_type          cmd;
   stat_type         stat;
   logic [WIDTH-1:0] d_w, x0_w, st_w;

   lcs_control u_ctrl (
      .clock, .reset, .start, .busy, .stat, .cmd, .rsp_valid, .rsp_status
   );

   lcs_datapath #(.WIDTH(WIDTH)) u_dp (
      .clock, .reset, .cmd, .stat, .req_coeff, .req_rhs, .req_modulus,
      .d_out(d_w), .x0_out(x0_w), .step_out(st_w)
   );

   // blank fields by status
   assign rsp_divisor        = (rsp_status == STATUS_ZEROMOD) ? '0 : d_w;
   assign rsp_first_solution = (rsp_status == STATUS_SOLVED) ? x0_w : '0;
   assign rsp_solution_step  = (rsp_status == STATUS_SOLVED) ? st_w : '0;
endmodule

// ===== sv/lcs_datapath.sv =====
// ----------------------------------------------------------------------------
// lcs_datapath
// Registers, a shared bit-serial divider and two bit-serial multiply units.
// ----------------------------------------------------------------------------
module lcs_datapath
   import lcs_pkg::*;
#(
   parameter int WIDTH = DefaultWidth
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output stat_type         stat,
   input  logic [WIDTH-1:0] req_coeff,
   input  logic [WIDTH-1:0] req_rhs,
   input  logic [WIDTH-1:0] req_modulus,
   output logic [WIDTH-1:0] d_out,
   output logic [WIDTH-1:0] x0_out,
   output logic [WIDTH-1:0] step_out
);
   localparam int CW = $clog2(WIDTH + 1);
   localparam int SW = WIDTH + 1; // signed coefficient width

   logic [WIDTH-1:0] n_ff, a_ff, b_ff, r0_ff, r1_ff, q_ff, k_ff, x0_ff, st_ff;
   logic [SW-1:0]    s0_ff, s1_ff, p_ff;
   logic [WIDTH-1:0] n_in, a_in, b_in, r0_in, r1_in, q_in, k_in, x0_in, st_in;
   logic [SW-1:0]    s0_in, s1_in, p_in;

   // divider: restoring, one quotient bit per cycle
   logic [WIDTH-1:0] dnum_ff, dden_ff, dquo_ff, drem_ff, dnum_in, dden_in, dquo_in, drem_in;
   logic [CW-1:0]    dcnt_ff, dcnt_in;
   logic             dbusy_ff, dbusy_in;
   logic [WIDTH:0]   dtrial;
   logic [WIDTH-1:0] drem_fin;
   logic             ddone;

   // serial multiply: q*s1 (shift-add) and mod multiply (add-double)
   logic [WIDTH-1:0] mx_ff, my_ff, macc_ff, mx_in, my_in, macc_in;
   logic [SW-1:0]    qm_ff, qm_in;
   logic [WIDTH-1:0] qq_ff, qq_in;
   logic             mbusy_ff, mbusy_in, qbusy_ff, qbusy_in, mdone, qdone;
   logic [WIDTH:0]   msum, mdbl;

   logic [WIDTH-1:0] s0_mag;
   logic [3:0]       last_op_ff, last_op_in;

   assign dtrial = {drem_ff, dnum_ff[WIDTH-1]} - {1'b0, dden_ff};
   // remainder after the step in progress
   assign drem_fin = dtrial[WIDTH] ? {drem_ff[WIDTH-2:0], dnum_ff[WIDTH-1]}
                                   : dtrial[WIDTH-1:0];
   assign ddone  = dbusy_ff && (dcnt_ff == CW'(1));
   assign msum   = {1'b0, macc_ff} + {1'b0, mx_ff};
   assign mdbl   = {1'b0, mx_ff} + {1'b0, mx_ff};
   assign mdone  = mbusy_ff && (my_ff == '0);
   assign qdone  = qbusy_ff && (qq_ff == '0);
   assign s0_mag = s0_ff[SW-1] ? WIDTH'(-s0_ff) : s0_ff[WIDTH-1:0];

   // next-state of datapath registers
   always_comb begin
      {n_in, a_in, b_in, r0_in, r1_in, q_in, k_in, x0_in, st_in} =
         {n_ff, a_ff, b_ff, r0_ff, r1_ff, q_ff, k_ff, x0_ff, st_ff};
      {s0_in, s1_in, p_in} = {s0_ff, s1_ff, p_ff};
      {dnum_in, dden_in, dquo_in, drem_in, dcnt_in, dbusy_in} =
         {dnum_ff, dden_ff, dquo_ff, drem_ff, dcnt_ff, dbusy_ff};
      {mx_in, my_in, macc_in, mbusy_in, qm_in, qq_in, qbusy_in} =
         {mx_ff, my_ff, macc_ff, mbusy_ff, qm_ff, qq_ff, qbusy_ff};
      last_op_in = last_op_ff;

      // advance divider
      if (dbusy_ff) begin
         dnum_in = {dnum_ff[WIDTH-2:0], 1'b0};
         if (!dtrial[WIDTH]) begin
            drem_in = dtrial[WIDTH-1:0];
            dquo_in = {dquo_ff[WIDTH-2:0], 1'b1};
         end else begin
            drem_in = {drem_ff[WIDTH-2:0], dnum_ff[WIDTH-1]};
            dquo_in = {dquo_ff[WIDTH-2:0], 1'b0};
         end
         dcnt_in = dcnt_ff - CW'(1);
         if (dcnt_ff == CW'(1)) dbusy_in = 1'b0;
      end
      // advance signed product q*s1
      if (qbusy_ff) begin
         if (qq_ff[0]) p_in = p_ff + qm_ff;
         qm_in = {qm_ff[SW-2:0], 1'b0};
         qq_in = {1'b0, qq_ff[WIDTH-1:1]};
         if (qdone) qbusy_in = 1'b0;
      end
      // advance modular multiply
      if (mbusy_ff) begin
         if (mdone) begin
            mbusy_in = 1'b0;
         end else begin
            if (my_ff[0])
               macc_in = (msum >= {1'b0, n_ff}) ? WIDTH'(msum - {1'b0, n_ff})
                                                : msum[WIDTH-1:0];
            mx_in = (mdbl >= {1'b0, n_ff}) ? WIDTH'(mdbl - {1'b0, n_ff})
                                           : mdbl[WIDTH-1:0];
            my_in = {1'b0, my_ff[WIDTH-1:1]};
         end
      end

      // capture divider results by the op that launched it
      if (ddone) begin
         case (last_op_ff)
            OP_DIV_A:  a_in = dtrial[WIDTH] ? {drem_ff[WIDTH-2:0], dnum_ff[WIDTH-1]}
                                            : dtrial[WIDTH-1:0];
            OP_DIV_B:  b_in = dtrial[WIDTH] ? {drem_ff[WIDTH-2:0], dnum_ff[WIDTH-1]}
                                            : dtrial[WIDTH-1:0];
            OP_DIV_Q:  q_in = {dquo_ff[WIDTH-2:0], !dtrial[WIDTH]};
            OP_DIV_BD: k_in = {dquo_ff[WIDTH-2:0], !dtrial[WIDTH]};
            OP_DIV_U:  x0_in = dtrial[WIDTH] ? {drem_ff[WIDTH-2:0], dnum_ff[WIDTH-1]}
                                             : dtrial[WIDTH-1:0];
            OP_DIV_NS: st_in = {dquo_ff[WIDTH-2:0], !dtrial[WIDTH]};
            default: ;
         endcase
      end
      if (mdone) x0_in = macc_ff;

      case (cmd.op)
         OP_LOAD: begin
            n_in = req_modulus; a_in = req_coeff; b_in = req_rhs;
            x0_in = '0; st_in = '0;
         end
         OP_DIV_A, OP_DIV_B, OP_DIV_Q, OP_DIV_BD, OP_DIV_U, OP_DIV_NS: begin
            case (cmd.op)
               OP_DIV_A:  begin dnum_in = a_ff;   dden_in = n_ff;  end
               OP_DIV_B:  begin dnum_in = b_ff;   dden_in = n_ff;  end
               OP_DIV_Q:  begin dnum_in = r0_ff;  dden_in = r1_ff; end
               OP_DIV_BD: begin dnum_in = b_ff;   dden_in = r0_ff; end
               OP_DIV_U:  begin dnum_in = s0_mag; dden_in = n_ff;  end
               default:   begin dnum_in = n_ff;   dden_in = r0_ff; end
            endcase
            drem_in = '0; dquo_in = '0; dcnt_in = CW'(WIDTH); dbusy_in = 1'b1;
            last_op_in = cmd.op;
            if (cmd.op == OP_DIV_A) begin
               s0_in = SW'(1); s1_in = '0;
            end
         end
         OP_QMUL: begin
            // quotient lands this cycle, take it straight from the divider
            p_in = '0; qm_in = s1_ff; qq_in = q_in; qbusy_in = 1'b1;
         end
         OP_EUCLID: begin
            // r0 - q*r1 equals the divider remainder
            r0_in = r1_ff; r1_in = drem_ff;
            s0_in = s1_ff; s1_in = s0_ff - p_ff;
         end
         OP_FIX_U: begin
            // negative u: n - (|u| mod n), zero stays zero
            if (s0_ff[SW-1] && x0_ff != '0) x0_in = n_ff - x0_ff;
         end
         OP_MULMOD: begin
            mx_in = x0_ff; my_in = k_ff; macc_in = '0; mbusy_in = 1'b1;
         end
         default: ;
      endcase
      // r0 seeded from reduced a after the first divide finishes
      if (ddone && last_op_ff == OP_DIV_A) begin
         r0_in = a_in; r1_in = n_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0; mbusy_ff <= 1'b0; qbusy_ff <= 1'b0;
         last_op_ff <= OP_NONE;
      end else begin
         dbusy_ff <= dbusy_in; mbusy_ff <= mbusy_in; qbusy_ff <= qbusy_in;
         last_op_ff <= last_op_in;
      end
      {n_ff, a_ff, b_ff, r0_ff, r1_ff, q_ff, k_ff, x0_ff, st_ff} <=
         {n_in, a_in, b_in, r0_in, r1_in, q_in, k_in, x0_in, st_in};
      {s0_ff, s1_ff, p_ff} <= {s0_in, s1_in, p_in};
      {dnum_ff, dden_ff, dquo_ff, drem_ff, dcnt_ff} <=
         {dnum_in, dden_in, dquo_in, drem_in, dcnt_in};
      {mx_ff, my_ff, macc_ff, qm_ff, qq_ff} <= {mx_in, my_in, macc_in, qm_in, qq_in};
   end

   assign stat.unit_done = ddone || mdone || qdone;
   assign stat.r1_zero   = (r1_ff == '0);
   assign stat.n_zero    = (n_ff == '0);
   assign stat.rem_zero  = (drem_fin == '0);
   assign d_out    = r0_ff;
   assign x0_out   = x0_ff;
   assign step_out = st_ff;

`ifndef NO_ASSERTIONS
   a_div_one_owner: assert property (@(posedge clock) disable iff (reset)
      !(dbusy_ff && mbusy_ff)) else $error("divider and multiplier both busy");
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      $rose(dbusy_ff) |-> dden_ff != '0) else $error("divide by zero launched");
   a_mul_reduced: assert property (@(posedge clock) disable iff (reset)
      mbusy_ff |-> macc_ff < n_ff) else $error("mod accumulator out of range");
`endif
endmodule

// ===== sv/lcs_control.sv =====
// ----------------------------------------------------------------------------
// lcs_control
// Sequencer: reduce, Euclid loop, solvability check, final multiply.
// ----------------------------------------------------------------------------
module lcs_control
   import lcs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  stat_type   stat,
   output cmd_type    cmd,
   output logic       rsp_valid,
   output logic [1:0] rsp_status
);
   localparam logic [3:0] S_IDLE = 4'd0, S_CHK = 4'd1, S_RA = 4'd2, S_RB = 4'd3,
      S_LOOP = 4'd4, S_Q = 4'd5, S_QM = 4'd6, S_BD = 4'd7, S_U = 4'd8,
      S_NS = 4'd9, S_FIX = 4'd10, S_MM = 4'd11, S_OUT = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [1:0] status_ff, status_in;

   always_comb begin
      state_in = state_ff; status_in = status_ff;
      cmd.op = OP_NONE;
      case (state_ff)
         S_IDLE: if (start) begin cmd.op = OP_LOAD; state_in = S_CHK; end
         S_CHK: begin
            if (stat.n_zero) begin status_in = STATUS_ZEROMOD; state_in = S_OUT; end
            else begin cmd.op = OP_DIV_A; state_in = S_RA; end
         end
         S_RA: if (stat.unit_done) begin
            cmd.op = OP_DIV_B; state_in = S_RB; end
         S_RB: if (stat.unit_done) state_in = S_LOOP;
         S_LOOP: begin
            if (stat.r1_zero) begin cmd.op = OP_DIV_BD; state_in = S_BD; end
            else begin cmd.op = OP_DIV_Q; state_in = S_Q; end
         end
         S_Q: if (stat.unit_done) begin
            cmd.op = OP_QMUL; state_in = S_QM; end
         S_QM: if (stat.unit_done) begin
            cmd.op = OP_EUCLID; state_in = S_LOOP; end
         S_BD: if (stat.unit_done) begin
            if (!stat.rem_zero) begin status_in = STATUS_NOSOL; state_in = S_OUT; end
            else begin cmd.op = OP_DIV_U; state_in = S_U; end
         end
         S_U: if (stat.unit_done) begin
            cmd.op = OP_DIV_NS; state_in = S_NS; end
         S_NS: if (stat.unit_done) begin cmd.op = OP_FIX_U; state_in = S_FIX; end
         S_FIX: begin cmd.op = OP_MULMOD; state_in = S_MM; end
         S_MM: if (stat.unit_done) begin
            status_in = STATUS_SOLVED; state_in = S_OUT; end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      status_ff <= status_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = (state_ff == S_OUT);
   assign rsp_status = status_ff;

`ifndef NO_ASSERTIONS
   a_out_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted item did not start");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3) else $error("bad status");
`endif
endmodule
